>>> hw/rtl/ucrr_pkg.sv
// ucrr_pkg: shared types, codes, microcode word layout and the descriptor rom
// for the usb control request responder; depends on nothing
package ucrr_pkg;

  // packet size and the cap on one response
  localparam int unsigned MAX_PACKET = 64;
  localparam int unsigned XFER_CAP   = (MAX_PACKET < 32) ? MAX_PACKET : 32;
  localparam logic [7:0]  MPS_BYTE   = 8'(MAX_PACKET);

  localparam int CNT_W    = 6;
  localparam int PTR_W    = 7;
  localparam int PC_W     = 4;
  localparam int PROG_LEN = 10;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_STALL = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SRC_ROM  = 2'd0,
    SRC_ZERO = 2'd1,
    SRC_CFG  = 2'd2
  } src_e;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_SET_ADDR = 3'd1,
    OP_SET_CFG  = 3'd2,
    OP_EVENTS   = 3'd3,
    OP_NEXT     = 3'd4
  } dp_op_e;

  typedef enum logic [1:0] {
    SEQ_NEXT    = 2'd0,
    SEQ_END     = 2'd1,
    SEQ_IF_ZERO = 2'd2,
    SEQ_LOOP    = 2'd3
  } seq_e;

  // one control word of the program
  typedef struct packed {
    logic            emit;
    kind_e           kind;
    logic            last_cnt;
    dp_op_e          op;
    seq_e            seq;
    logic [PC_W-1:0] target;
  } ucw_t;

  // program entry points
  localparam logic [PC_W-1:0] PC_STALL    = 4'd0;
  localparam logic [PC_W-1:0] PC_ACK      = 4'd1;
  localparam logic [PC_W-1:0] PC_SET_ADDR = 4'd2;
  localparam logic [PC_W-1:0] PC_SET_CFG  = 4'd4;
  localparam logic [PC_W-1:0] PC_DATA     = 4'd6;
  localparam logic [PC_W-1:0] PC_STREAM   = 4'd7;
  localparam logic [PC_W-1:0] PC_EMPTY    = 4'd8;
  localparam logic [PC_W-1:0] PC_EVENTS   = 4'd9;

  // descriptor rom layout
  localparam logic [PTR_W-1:0] ROM_DEV  = 7'd0;
  localparam logic [PTR_W-1:0] ROM_CFG  = 7'd18;
  localparam logic [PTR_W-1:0] ROM_LANG = 7'd50;
  localparam logic [PTR_W-1:0] ROM_MFR  = 7'd54;
  localparam logic [PTR_W-1:0] ROM_PROD = 7'd64;

  // standard request codes
  localparam logic [7:0] REQ_GET_STAT      = 8'h00;
  localparam logic [7:0] REQ_CLR_FEAT      = 8'h01;
  localparam logic [7:0] REQ_SET_FEAT      = 8'h03;
  localparam logic [7:0] REQ_SET_ADDR      = 8'h05;
  localparam logic [7:0] REQ_GET_DESC      = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
  localparam logic [7:0] REQ_GET_IFACE     = 8'h0a;
  localparam logic [7:0] REQ_SET_IFACE     = 8'h0b;

  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;

  // register indexes on the apb port
  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_VENDOR  = 2'd1;
  localparam logic [1:0] REG_PRODUCT = 2'd2;

  // per-request setup handed to the datapath
  typedef struct packed {
    logic             load;
    logic [PTR_W-1:0] base;
    logic [CNT_W-1:0] count;
    src_e             src;
    logic [7:0]       arg;
  } dp_load_t;

  // step control from the sequencer
  typedef struct packed {
    logic   fire;
    logic   emit;
    kind_e  kind;
    logic   last_cnt;
    dp_op_e op;
  } dp_ctrl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic out_free;
  } dp_stat_t;

  // fixed descriptor contents; id bytes are patched in the datapath
  function automatic logic [7:0] rom_byte(input logic [PTR_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      7'd0:                 b = 8'd18;
      7'd1:                 b = 8'h01;
      7'd3:                 b = 8'h02;
      7'd4, 7'd5, 7'd6:     b = 8'hff;
      7'd7:                 b = MPS_BYTE;
      7'd13, 7'd14:         b = 8'h01;
      7'd15:                b = 8'h02;
      7'd17:                b = 8'h01;
      // configuration
      7'd18:                b = 8'h09;
      7'd19:                b = 8'h02;
      7'd20:                b = 8'h20;
      7'd22, 7'd23:         b = 8'h01;
      7'd25:                b = 8'h80;
      7'd26:                b = 8'hfa;
      // interface
      7'd27:                b = 8'h09;
      7'd28:                b = 8'h04;
      7'd31:                b = 8'h02;
      7'd32, 7'd33, 7'd34:  b = 8'hff;
      // endpoints
      7'd36:                b = 8'h07;
      7'd37:                b = 8'h05;
      7'd38:                b = 8'h81;
      7'd39:                b = 8'h02;
      7'd40:                b = MPS_BYTE;
      7'd43:                b = 8'h07;
      7'd44:                b = 8'h05;
      7'd45, 7'd46:         b = 8'h02;
      7'd47:                b = MPS_BYTE;
      // string 0, language list
      7'd50:                b = 8'h04;
      7'd51:                b = 8'h03;
      7'd52:                b = 8'h09;
      7'd53:                b = 8'h04;
      // string 1
      7'd54:                b = 8'h0a;
      7'd55:                b = 8'h03;
      7'd56:                b = 8'h4d;
      7'd58:                b = 8'h56;
      7'd60, 7'd62:         b = 8'h49;
      // string 2
      7'd64:                b = 8'h1a;
      7'd65:                b = 8'h03;
      7'd66:                b = 8'h4a;
      7'd68:                b = 8'h33;
      7'd70:                b = 8'h36;
      7'd72:                b = 8'h20;
      7'd74:                b = 8'h43;
      7'd76, 7'd82:         b = 8'h6f;
      7'd78:                b = 8'h6e;
      7'd80:                b = 8'h73;
      7'd84:                b = 8'h6c;
      7'd86:                b = 8'h65;
      default:              b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/usb_control_request_responder_core.sv
// usb control request responder: setup decode, apb registers and handshakes
// order: the input is stalled while a request runs; a stall or ack beat passes
// the step counter, then the output register; a set runs its update step before
// its ack, data a count check before the first beat, then 1 beat a cycle while
// the output takes them; one microcode step a cycle unless the output holds it
// reset: asynchronous, active low; clears registers, address and configured flag
module usb_control_request_responder_core import ucrr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // setup and event input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_length_i,
  input  logic [7:0]  bus_events_i,
  // response output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  response_kind_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  output logic [6:0]  device_address_o,
  output logic        is_configured_o
);

  logic        enabled_q;
  logic [15:0] vendor_id_q;
  logic [15:0] product_id_q;
  logic [1:0]  reg_idx;
  logic        reg_wr;

  // apb registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b0;
      vendor_id_q  <= '0;
      product_id_q <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_ENABLED: enabled_q    <= pwdata[0];
        REG_VENDOR:  vendor_id_q  <= pwdata[15:0];
        REG_PRODUCT: product_id_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLED: prdata = {31'd0, enabled_q};
      REG_VENDOR:  prdata = {16'd0, vendor_id_q};
      REG_PRODUCT: prdata = {16'd0, product_id_q};
      default:     prdata = '0;
    endcase
  end

  // input beat and request start
  logic busy;
  logic in_accept;
  logic start;

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i & ~busy;
  assign start      = in_accept & enabled_q;

  // setup decode
  logic             to_host;
  logic [PC_W-1:0]  entry;
  src_e             src;
  logic [PTR_W-1:0] base;
  logic             use_rom;
  logic [7:0]       fixed_len;
  logic [7:0]       arg;
  logic [7:0]       full_len;
  logic [CNT_W-1:0] cap_len;
  logic [CNT_W-1:0] count;

  assign to_host = request_type_i[7];

  always_comb begin
    entry     = PC_STALL;
    src       = SRC_ZERO;
    base      = ROM_DEV;
    use_rom   = 1'b0;
    fixed_len = 8'd0;
    arg       = request_value_i[7:0];
    if (func_i) begin
      entry = PC_EVENTS;
      arg   = bus_events_i;
    end else begin
      unique case (request_code_i)
        REQ_GET_STAT: begin
          if (to_host) begin
            entry     = PC_DATA;
            fixed_len = 8'd2;
          end
        end
        REQ_CLR_FEAT, REQ_SET_FEAT, REQ_SET_IFACE: begin
          if (!to_host) entry = PC_ACK;
        end
        REQ_SET_ADDR: begin
          if (!to_host) entry = PC_SET_ADDR;
        end
        REQ_GET_DESC: begin
          if (to_host) begin
            priority if (request_value_i[15:8] == DT_DEVICE) begin
              base = ROM_DEV;  use_rom = 1'b1;
            end else if (request_value_i[15:8] == DT_CONFIG) begin
              base = ROM_CFG;  use_rom = 1'b1;
            end else if (request_value_i[15:8] == DT_STRING) begin
              priority if (request_value_i[7:0] == 8'd0) begin
                base = ROM_LANG; use_rom = 1'b1;
              end else if (request_value_i[7:0] == 8'd1) begin
                base = ROM_MFR;  use_rom = 1'b1;
              end else if (request_value_i[7:0] == 8'd2) begin
                base = ROM_PROD; use_rom = 1'b1;
              end else begin
                use_rom = 1'b0;
              end
            end else begin
              use_rom = 1'b0;
            end
            if (use_rom) begin
              entry = PC_DATA;
              src   = SRC_ROM;
            end
          end
        end
        REQ_GET_CONFIG: begin
          if (to_host) begin
            entry     = PC_DATA;
            src       = SRC_CFG;
            fixed_len = 8'd1;
          end
        end
        REQ_SET_CONFIG: begin
          if (!to_host) entry = PC_SET_CFG;
        end
        REQ_GET_IFACE: begin
          if (to_host) begin
            entry     = PC_DATA;
            fixed_len = 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // byte count: least of descriptor length, cap and wLength
  assign full_len = use_rom ? rom_byte(base) : fixed_len;
  assign cap_len  = (full_len > 8'(XFER_CAP)) ? CNT_W'(XFER_CAP) : full_len[CNT_W-1:0];
  assign count    = ({10'd0, cap_len} > request_length_i) ?
                    request_length_i[CNT_W-1:0] : cap_len;

  dp_load_t load;
  dp_ctrl_t ctrl;
  dp_stat_t stat;

  assign load = '{load: start, base: base, count: count, src: src, arg: arg};

  ucrr_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .entry_i (entry),
    .stat_i  (stat),
    .busy_o  (busy),
    .ctrl_o  (ctrl)
  );

  ucrr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (load),
    .ctrl_i           (ctrl),
    .vendor_id_i      (vendor_id_q),
    .product_id_i     (product_id_q),
    .out_stall_i      (out_stall_i),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .response_kind_o  (response_kind_o),
    .data_byte_o      (data_byte_o),
    .last_o           (last_o),
    .device_address_o (device_address_o),
    .is_configured_o  (is_configured_o)
  );

endmodule

>>> hw/rtl/ucrr_seq.sv
// ucrr_seq: microcode sequencer with program table, step counter and jumps
// depends on ucrr_pkg
module ucrr_seq import ucrr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [PC_W-1:0] entry_i,
  input  dp_stat_t        stat_i,
  output logic            busy_o,
  output dp_ctrl_t        ctrl_o
);

  // program table
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{emit: 1'b1, kind: KIND_STALL, last_cnt: 1'b0, op: OP_NONE,
          seq: SEQ_END, target: PC_STALL};
    unique case (pc)
      PC_STALL: ;
      PC_ACK: w.kind = KIND_ACK;
      PC_SET_ADDR: begin
        w.emit = 1'b0;
        w.op   = OP_SET_ADDR;
        w.seq  = SEQ_NEXT;
      end
      PC_SET_ADDR + 4'd1: w.kind = KIND_ACK;
      PC_SET_CFG: begin
        w.emit = 1'b0;
        w.op   = OP_SET_CFG;
        w.seq  = SEQ_NEXT;
      end
      PC_SET_CFG + 4'd1: w.kind = KIND_ACK;
      PC_DATA: begin
        w.emit   = 1'b0;
        w.seq    = SEQ_IF_ZERO;
        w.target = PC_EMPTY;
      end
      PC_STREAM: begin
        w.kind     = KIND_DATA;
        w.last_cnt = 1'b1;
        w.op       = OP_NEXT;
        w.seq      = SEQ_LOOP;
        w.target   = PC_STREAM;
      end
      PC_EMPTY: w.kind = KIND_EMPTY;
      PC_EVENTS: begin
        w.emit = 1'b0;
        w.op   = OP_EVENTS;
      end
      default: ;
    endcase
    return w;
  endfunction

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ucw_t            uw;
  logic            fire;

  // current step, held while its result cannot be stored
  assign uw   = ucode(pc_q);
  assign fire = busy_q & (~uw.emit | stat_i.out_free);

  assign ctrl_o = '{fire: fire, emit: uw.emit, kind: uw.kind,
                    last_cnt: uw.last_cnt, op: uw.op};
  assign busy_o = busy_q;

  // step counter and jumps
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = entry_i;
    end else if (fire) begin
      unique case (uw.seq)
        SEQ_NEXT: pc_d = pc_q + 4'd1;
        SEQ_END:  busy_d = 1'b0;
        SEQ_IF_ZERO: pc_d = stat_i.cnt_zero ? uw.target : pc_q + 4'd1;
        SEQ_LOOP: begin
          if (stat_i.cnt_one) begin
            busy_d = 1'b0;
          end else begin
            pc_d = uw.target;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_STALL;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

`ifndef SYNTHESIS
  // step counter stays inside the program
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q < 4'(PROG_LEN)))
    else $error("ucrr_seq: step counter outside program");

  // a step blocked on the output holds its place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !fire) |=> (busy_q && $stable(pc_q)))
    else $error("ucrr_seq: blocked step lost");

  // a new request only starts while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("ucrr_seq: start while busy");
`endif

endmodule

>>> hw/rtl/ucrr_dp.sv
// ucrr_dp: datapath with byte pointer, count, device state and output register
// depends on ucrr_pkg
module ucrr_dp import ucrr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_load_t    load_i,
  input  dp_ctrl_t    ctrl_i,
  input  logic [15:0] vendor_id_i,
  input  logic [15:0] product_id_i,
  input  logic        out_stall_i,
  output dp_stat_t    stat_o,
  output logic        out_valid_o,
  output logic [1:0]  response_kind_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  output logic [6:0]  device_address_o,
  output logic        is_configured_o
);

  logic [PTR_W-1:0] ptr_q;
  logic [CNT_W-1:0] cnt_q;
  src_e             src_q;
  logic [7:0]       arg_q;
  logic [6:0]       addr_q;
  logic             cfg_q;
  logic [7:0]       prev_q;
  logic             out_valid_q;
  kind_e            kind_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic [6:0]       oaddr_q;
  logic             ocfg_q;

  logic [7:0] edges;
  logic [7:0] src_byte;
  logic       out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign stat_o   = '{cnt_zero: (cnt_q == '0), cnt_one: (cnt_q == 6'd1),
                      out_free: out_free};
  assign edges    = arg_q & ~prev_q;

  // byte source with id patch
  always_comb begin
    unique case (src_q)
      SRC_ROM: begin
        unique case (ptr_q)
          ROM_DEV + 7'd8:  src_byte = vendor_id_i[7:0];
          ROM_DEV + 7'd9:  src_byte = vendor_id_i[15:8];
          ROM_DEV + 7'd10: src_byte = product_id_i[7:0];
          ROM_DEV + 7'd11: src_byte = product_id_i[15:8];
          default:         src_byte = rom_byte(ptr_q);
        endcase
      end
      SRC_CFG: src_byte = {7'd0, cfg_q};
      default: src_byte = 8'h00;
    endcase
  end

  // per-request working registers
  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      ptr_q <= load_i.base;
      cnt_q <= load_i.count;
      src_q <= load_i.src;
      arg_q <= load_i.arg;
    end else if (ctrl_i.fire && ctrl_i.op == OP_NEXT) begin
      ptr_q <= ptr_q + 7'd1;
      cnt_q <= cnt_q - 6'd1;
    end
  end

  // device address, configured flag and event history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      cfg_q  <= 1'b0;
      prev_q <= '0;
    end else if (ctrl_i.fire) begin
      unique case (ctrl_i.op)
        OP_SET_ADDR: addr_q <= arg_q[6:0];
        OP_SET_CFG:  cfg_q  <= (arg_q == 8'd1);
        OP_EVENTS: begin
          prev_q <= arg_q;
          if (edges[2]) begin
            addr_q <= '0;
            cfg_q  <= 1'b0;
          end
          if (edges[5]) begin
            cfg_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.fire && ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire && ctrl_i.emit) begin
      kind_q  <= ctrl_i.kind;
      byte_q  <= (ctrl_i.kind == KIND_DATA) ? src_byte : 8'h00;
      last_q  <= ctrl_i.last_cnt ? (cnt_q == 6'd1) : 1'b1;
      oaddr_q <= addr_q;
      ocfg_q  <= cfg_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign response_kind_o  = kind_q;
  assign data_byte_o      = byte_q;
  assign last_o           = last_q;
  assign device_address_o = oaddr_q;
  assign is_configured_o  = ocfg_q;

`ifndef SYNTHESIS
  // streaming never runs past the byte count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.fire && ctrl_i.op == OP_NEXT) |-> (cnt_q != '0))
    else $error("ucrr_dp: stream step with zero count");
`endif

endmodule

>>> test/testbench.sv
// testbench for usb_control_request_responder_core: table-driven and random setup
// requests with a behavioural predictor of the responder; depends on ucrr_pkg and the core
module testbench;
  import ucrr_pkg::*;

  localparam logic       FUNC_SETUP  = 1'b0;
  localparam logic       FUNC_EVENTS = 1'b1;
  localparam logic [7:0] DIR_IN      = 8'h80;
  localparam logic [7:0] DIR_OUT     = 8'h00;
  localparam int         EV_RESET    = 2;
  localparam int         EV_DISC     = 5;
  localparam logic [7:0] CFG_ON      = 8'd1;
  localparam int         STRING_CNT  = 3;
  localparam int         BEAT_CAP    = 32;
  localparam logic       BY_MODEL    = 1'b0;
  localparam logic       BY_TABLE    = 1'b1;
  localparam int         SETTLE      = 8;
  localparam int         IDLE_LIMIT  = 2000;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
    logic [6:0] addr;
    logic       cfg;
  } reply_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] wlen;
    logic [7:0]  events;
    logic        typed;
    reply_t      want;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid, in_stall;
  logic        func;
  logic [7:0]  request_type, request_code, bus_events;
  logic [15:0] request_value, request_length;
  logic        out_valid, last;
  logic        out_stall = 1'b0;
  logic [1:0]  response_kind;
  logic [7:0]  data_byte;
  logic [6:0]  device_address;
  logic        is_configured;

  // predictor state and register copies
  logic        en_r, cfg_flag;
  logic [15:0] vid_r, pid_r;
  logic [6:0]  dev_addr;
  logic [7:0]  prev_ev;
  logic [7:0]  tx_buf [BEAT_CAP];

  reply_t   step_replies [$];
  reply_t   reply_q [$];
  request_t plan [$];

  int  fault_cnt   = 0;
  int  shown_cnt   = 0;
  int  idle_cycles = 0;
  int  stall_left  = 0;
  logic in_quiet   = 1'b0;
  logic out_quiet  = 1'b0;

  // descriptor contents, id bytes patched from the registers
  logic [7:0] desc_rom [0:89] = '{
    8'd18, 8'h01, 8'h00, 8'h02, 8'hff, 8'hff, 8'hff, MPS_BYTE,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h02, 8'h00, 8'h01,
    8'h09, 8'h02, 8'd32, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'hfa,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hff, 8'hff, 8'hff, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h02, MPS_BYTE, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h02, 8'h02, MPS_BYTE, 8'h00, 8'h00,
    8'h04, 8'h03, 8'h09, 8'h04,
    8'd10, 8'h03, 8'h4d, 8'h00, 8'h56, 8'h00, 8'h49, 8'h00, 8'h49, 8'h00,
    8'd26, 8'h03, 8'h4a, 8'h00, 8'h33, 8'h00, 8'h36, 8'h00, 8'h20, 8'h00,
    8'h43, 8'h00, 8'h6f, 8'h00, 8'h6e, 8'h00, 8'h73, 8'h00, 8'h6f, 8'h00,
    8'h6c, 8'h00, 8'h65, 8'h00, 8'h00, 8'h00
  };

  usb_control_request_responder_core u_top (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (func),
    .request_type_i   (request_type),
    .request_code_i   (request_code),
    .request_value_i  (request_value),
    .request_length_i (request_length),
    .bus_events_i     (bus_events),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .response_kind_o  (response_kind),
    .data_byte_o      (data_byte),
    .last_o           (last),
    .device_address_o (device_address),
    .is_configured_o  (is_configured)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap(logic quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic void push_reply(kind_e k, logic [7:0] d, logic l);
    reply_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    r.addr = dev_addr;
    r.cfg  = cfg_flag;
    step_replies.push_back(r);
  endfunction

  // one beat per byte, capped by wLength, the packet size and the beat cap
  function automatic void stream_buf(int unsigned len, int unsigned wlen);
    int unsigned n;
    n = len;
    if (n > wlen) n = wlen;
    if (n > MAX_PACKET) n = MAX_PACKET;
    if (n > BEAT_CAP) n = BEAT_CAP;
    if (n == 0) push_reply(KIND_EMPTY, 8'h00, 1'b1);
    for (int unsigned i = 0; i < n; i++) push_reply(KIND_DATA, tx_buf[i], i == n - 1);
  endfunction

  function automatic logic [7:0] desc_byte(int unsigned idx);
    case (idx)
      ROM_DEV + 8:  return vid_r[7:0];
      ROM_DEV + 9:  return vid_r[15:8];
      ROM_DEV + 10: return pid_r[7:0];
      ROM_DEV + 11: return pid_r[15:8];
      default:      return desc_rom[idx];
    endcase
  endfunction

  function automatic void stream_desc(int unsigned base, int unsigned wlen);
    int unsigned len;
    len = desc_byte(base);
    if (len > BEAT_CAP) len = BEAT_CAP;
    for (int unsigned i = 0; i < len; i++) tx_buf[i] = desc_byte(base + i);
    stream_buf(len, wlen);
  endfunction

  function automatic void answer_setup(request_t q);
    logic       to_host;
    logic       done;
    logic [7:0] dtype, didx;
    to_host = q.rtype[7];
    dtype   = q.value[15:8];
    didx    = q.value[7:0];
    done    = 1'b0;
    case (q.code)
      REQ_GET_STAT: if (to_host) begin
        tx_buf[0] = 8'h00;
        tx_buf[1] = 8'h00;
        stream_buf(2, q.wlen);
        done = 1'b1;
      end
      REQ_CLR_FEAT, REQ_SET_FEAT, REQ_SET_IFACE: if (!to_host) begin
        push_reply(KIND_ACK, 8'h00, 1'b1);
        done = 1'b1;
      end
      REQ_SET_ADDR: if (!to_host) begin
        dev_addr = q.value[6:0];
        push_reply(KIND_ACK, 8'h00, 1'b1);
        done = 1'b1;
      end
      REQ_GET_DESC: if (to_host) begin
        done = 1'b1;
        if (dtype == DT_DEVICE) stream_desc(ROM_DEV, q.wlen);
        else if (dtype == DT_CONFIG) stream_desc(ROM_CFG, q.wlen);
        else if (dtype == DT_STRING && didx == 8'd0) stream_desc(ROM_LANG, q.wlen);
        else if (dtype == DT_STRING && didx == 8'd1) stream_desc(ROM_MFR, q.wlen);
        else if (dtype == DT_STRING && didx == 8'd2) stream_desc(ROM_PROD, q.wlen);
        else done = 1'b0;
      end
      REQ_GET_CONFIG: if (to_host) begin
        tx_buf[0] = {7'd0, cfg_flag};
        stream_buf(1, q.wlen);
        done = 1'b1;
      end
      REQ_SET_CONFIG: if (!to_host) begin
        cfg_flag = (q.value[7:0] == CFG_ON);
        push_reply(KIND_ACK, 8'h00, 1'b1);
        done = 1'b1;
      end
      REQ_GET_IFACE: if (to_host) begin
        tx_buf[0] = 8'h00;
        stream_buf(1, q.wlen);
        done = 1'b1;
      end
      default: ;
    endcase
    if (!done) push_reply(KIND_STALL, 8'h00, 1'b1);
  endfunction

  // replies to one item land in step_replies
  function automatic void answer_request(request_t q);
    logic [7:0] edges;
    step_replies.delete();
    if (!en_r) return;
    if (q.func == FUNC_EVENTS) begin
      edges   = q.events & ~prev_ev;
      prev_ev = q.events;
      if (edges[EV_RESET]) begin
        cfg_flag = 1'b0;
        dev_addr = '0;
      end
      if (edges[EV_DISC]) cfg_flag = 1'b0;
    end else begin
      answer_setup(q);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_row(logic f, logic [7:0] rt, logic [7:0] code,
                                  logic [15:0] v, logic [15:0] l, logic [7:0] ev,
                                  logic t, kind_e k, logic [7:0] d, logic [6:0] a,
                                  logic c);
    request_t q;
    q.func      = f;
    q.rtype     = rt;
    q.code      = code;
    q.value     = v;
    q.wlen      = l;
    q.events    = ev;
    q.typed     = t;
    q.want.kind = k;
    q.want.data = d;
    q.want.last = 1'b1;
    q.want.addr = a;
    q.want.cfg  = c;
    plan.push_back(q);
  endfunction

  // mostly well-formed requests with random content, some noise
  function automatic request_t random_req();
    request_t q;
    logic     to_host;
    int       pick;
    q.func   = FUNC_SETUP;
    q.rtype  = 8'($urandom);
    q.code   = 8'($urandom);
    q.value  = 16'($urandom);
    q.wlen   = 16'($urandom);
    q.events = 8'($urandom);
    q.typed  = BY_MODEL;
    q.want   = '0;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      q.func   = FUNC_EVENTS;
      q.events = prev_ev;
      case ($urandom_range(0, 3))
        0: q.events[EV_RESET] = ~q.events[EV_RESET];
        1: q.events[EV_DISC] = ~q.events[EV_DISC];
        2: begin
          q.events[EV_RESET] = ~q.events[EV_RESET];
          q.events[EV_DISC]  = ~q.events[EV_DISC];
        end
        default: q.events = 8'($urandom);
      endcase
    end else if (pick < 90) begin
      case ($urandom_range(0, 11))
        0:       begin q.code = REQ_GET_STAT;      to_host = 1'b1; end
        5:       begin q.code = REQ_GET_CONFIG;    to_host = 1'b1; end
        6:       begin q.code = REQ_GET_IFACE;     to_host = 1'b1; end
        7:       begin q.code = REQ_CLR_FEAT;      to_host = 1'b0; end
        8:       begin q.code = REQ_SET_FEAT;      to_host = 1'b0; end
        9:       begin q.code = REQ_SET_ADDR;      to_host = 1'b0; end
        10:      begin q.code = REQ_SET_CONFIG;    to_host = 1'b0; end
        11:      begin q.code = REQ_SET_IFACE;     to_host = 1'b0; end
        default: begin q.code = REQ_GET_DESC;      to_host = 1'b1; end
      endcase
      q.rtype[7] = to_host ^ ($urandom_range(0, 19) == 0);
      if (q.code == REQ_GET_DESC) begin
        q.value[15:8] = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(1, 3));
        q.value[7:0]  = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, STRING_CNT - 1));
      end
      if (q.code == REQ_SET_CONFIG && $urandom_range(0, 2) != 0)
        q.value[7:0] = 8'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       q.wlen = 16'd0;
        1, 2:    q.wlen = 16'($urandom_range(1, 40));
        3:       q.wlen = 16'hffff;
        default: ;
      endcase
    end
    return q;
  endfunction

  // one beat on the input side, predicted once accepted
  task automatic send_item(request_t q);
    int gap;
    gap = pick_gap(in_quiet);
    if ($urandom_range(0, 39) == 0) in_quiet = ~in_quiet;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       = 1'b1;
    func           = q.func;
    request_type   = q.rtype;
    request_code   = q.code;
    request_value  = q.value;
    request_length = q.wlen;
    bus_events     = q.events;
    do @(posedge clk); while (in_stall !== 1'b0);
    answer_request(q);
    if (q.typed == BY_TABLE) reply_q.push_back(q.want);
    else foreach (step_replies[i]) reply_q.push_back(step_replies[i]);
  endtask

  // sender holds off until every reply is back and the block has settled
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_ENABLED: en_r  = val[0];
      REG_VENDOR:  vid_r = val[15:0];
      REG_PRODUCT: pid_r = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic run_phase(logic en, logic [15:0] vid, logic [15:0] pid, int n);
    wait_idle();
    write_reg(REG_ENABLED, {31'd0, en});
    write_reg(REG_VENDOR, {16'd0, vid});
    write_reg(REG_PRODUCT, {16'd0, pid});
    for (int i = 0; i < n; i++) send_item(random_req());
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    func           = FUNC_SETUP;
    request_type   = '0;
    request_code   = '0;
    request_value  = '0;
    request_length = '0;
    bus_events     = '0;
    en_r           = 1'b0;
    vid_r          = '0;
    pid_r          = '0;
    cfg_flag       = 1'b0;
    dev_addr       = '0;
    prev_ev        = '0;
    repeat (7) @(negedge clk);
    rst_ni = 1'b1;

    write_reg(REG_VENDOR, 32'h0000_ffff);
    write_reg(REG_PRODUCT, 32'h0000_0000);
    write_reg(REG_ENABLED, 32'h0000_0001);

    // directed table: typed rows carry their single reply
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_STAT, 16'h0000, 16'd2, 8'h00,
            BY_MODEL, KIND_DATA, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_OUT, REQ_GET_STAT, 16'h0000, 16'd2, 8'h00,
            BY_TABLE, KIND_STALL, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_DESC, {DT_DEVICE, 8'd0}, 16'hffff, 8'h00,
            BY_MODEL, KIND_DATA, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_DESC, {DT_CONFIG, 8'd0}, 16'hffff, 8'h00,
            BY_MODEL, KIND_DATA, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_DESC, {DT_STRING, 8'd0}, 16'd255, 8'h00,
            BY_MODEL, KIND_DATA, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_DESC, {DT_STRING, 8'd1}, 16'd3, 8'h00,
            BY_MODEL, KIND_DATA, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_DESC, {DT_STRING, 8'd2}, 16'hffff, 8'h00,
            BY_MODEL, KIND_DATA, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_DESC, {DT_STRING, 8'd3}, 16'hffff, 8'h00,
            BY_TABLE, KIND_STALL, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_DESC, 16'h0400, 16'hffff, 8'h00,
            BY_TABLE, KIND_STALL, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_DESC, {DT_DEVICE, 8'd0}, 16'd0, 8'h00,
            BY_TABLE, KIND_EMPTY, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_OUT, REQ_SET_ADDR, 16'h007f, 16'd0, 8'h00,
            BY_TABLE, KIND_ACK, 8'h00, 7'h7f, 1'b0);
    add_row(FUNC_SETUP, DIR_OUT, REQ_SET_CONFIG, 16'h0001, 16'd0, 8'h00,
            BY_TABLE, KIND_ACK, 8'h00, 7'h7f, 1'b1);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_CONFIG, 16'h0000, 16'd1, 8'h00,
            BY_TABLE, KIND_DATA, 8'h01, 7'h7f, 1'b1);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_IFACE, 16'h0000, 16'd1, 8'h00,
            BY_MODEL, KIND_DATA, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_OUT, REQ_CLR_FEAT, 16'h0000, 16'd0, 8'h00,
            BY_TABLE, KIND_ACK, 8'h00, 7'h7f, 1'b1);
    add_row(FUNC_SETUP, 8'h02, REQ_SET_FEAT, 16'h0001, 16'd0, 8'h00,
            BY_TABLE, KIND_ACK, 8'h00, 7'h7f, 1'b1);
    add_row(FUNC_SETUP, 8'h01, REQ_SET_IFACE, 16'h0000, 16'd0, 8'h00,
            BY_TABLE, KIND_ACK, 8'h00, 7'h7f, 1'b1);
    add_row(FUNC_SETUP, 8'hff, 8'hff, 16'hffff, 16'hffff, 8'hff,
            BY_TABLE, KIND_STALL, 8'h00, 7'h7f, 1'b1);
    // disconnect edge drops the configuration only
    add_row(FUNC_EVENTS, 8'h00, 8'h00, 16'h0000, 16'd0, 8'h20,
            BY_MODEL, KIND_DATA, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_CONFIG, 16'h0000, 16'hffff, 8'h00,
            BY_TABLE, KIND_DATA, 8'h00, 7'h7f, 1'b0);
    add_row(FUNC_SETUP, DIR_OUT, REQ_SET_CONFIG, 16'hff01, 16'd0, 8'h00,
            BY_TABLE, KIND_ACK, 8'h00, 7'h7f, 1'b1);
    // bus reset edge clears address and configuration
    add_row(FUNC_EVENTS, 8'h00, 8'h00, 16'h0000, 16'd0, 8'hff,
            BY_MODEL, KIND_DATA, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_IN, REQ_GET_STAT, 16'h0000, 16'd1, 8'h00,
            BY_MODEL, KIND_DATA, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_SETUP, DIR_IN, REQ_SET_ADDR, 16'h0011, 16'd0, 8'h00,
            BY_TABLE, KIND_STALL, 8'h00, 7'h00, 1'b0);
    add_row(FUNC_EVENTS, 8'h00, 8'h00, 16'h0000, 16'd0, 8'h00,
            BY_MODEL, KIND_DATA, 8'h00, 7'h00, 1'b0);
    foreach (plan[i]) send_item(plan[i]);

    // random phases over several register settings, one detached
    run_phase(1'b1, 16'h0000, 16'hffff, 125);
    run_phase(1'b1, 16'($urandom), 16'($urandom), 125);
    run_phase(1'b0, 16'($urandom), 16'($urandom), 20);
    run_phase(1'b1, 16'($urandom), 16'($urandom), 125);

    wait_idle();
    repeat (4 * SETTLE) @(posedge clk);
    if (fault_cnt == 0 && reply_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------- output side

  // receiver stall pattern, with quiet stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) out_quiet = ~out_quiet;
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else begin
      stall_left = pick_gap(out_quiet);
      out_stall  = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // compare each accepted beat with the oldest expected reply
  always @(posedge clk) begin : check_beats
    reply_t want;
    if (rst_ni && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (reply_q.size() == 0) begin
        fault_cnt++;
        if (shown_cnt < 10) begin
          shown_cnt++;
          $display("unexpected beat: kind=%0d data=%02h last=%0d addr=%02h cfg=%0d",
                   response_kind, data_byte, last, device_address, is_configured);
        end
      end else begin
        want = reply_q.pop_front();
        if (response_kind !== want.kind || data_byte !== want.data || last !== want.last ||
            device_address !== want.addr || is_configured !== want.cfg) begin
          fault_cnt++;
          if (shown_cnt < 10) begin
            shown_cnt++;
            $display("mismatch: exp kind=%0d data=%02h last=%0d addr=%02h cfg=%0d",
                     want.kind, want.data, want.last, want.addr, want.cfg);
            $display("          got kind=%0d data=%02h last=%0d addr=%02h cfg=%0d",
                     response_kind, data_byte, last, device_address, is_configured);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat or register access
  always @(posedge clk) begin
    if (!rst_ni || psel || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
